@@ rtl/cub_pkg.sv @@
// Shared constants and types for the combination unranking block.
package cub_pkg;

  localparam int unsigned MAX_SET_SIZE_DEF = 64;
  localparam int unsigned RANK_BITS_DEF    = 32;

  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned RANK_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned S_DATA_W = ((SIZE_W + RANK_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SET_SIZE_RST = SIZE_W'(64);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SIZE_ERR = 2'd1,
    STATUS_RANK_ERR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_BUILD,
    ST_DRAIN,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_RESULT
  } state_e;

endpackage

@@ rtl/cub_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cub_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/combination_unrank_bitmask.sv @@
// Top level: lexicographic combination unranking to a position bit mask.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+--------------------------------
//  config   | in        | cfg_wen_i                     | cfg_wdata_i: set_size
//  request  | in        | s_axis_tvalid / s_axis_tready | s_axis_tdata: subset_size, rank
//  result   | out       | m_axis_tvalid / m_axis_tready | m_axis_tdata: subset_mask,
//           |           |                               | m_axis_tuser: status
//
// After reset the block fills a saturated Pascal table in RAM, one word per cycle, and no
// request is taken until the table is built.
// A request with a size error goes from IDLE straight to RESULT; otherwise CHECK tests the
// rank, and a rank error goes to RESULT, else the walk does one table read per position,
// overlapped with the decision on the previous position. One request is in work at a time;
// a finished result waits in the output register while the next request is taken.
module combination_unrank_bitmask #(
  parameter int unsigned MAX_SET_SIZE = cub_pkg::MAX_SET_SIZE_DEF,
  parameter int unsigned RANK_BITS    = cub_pkg::RANK_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wen_i,
  input  logic [cub_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [6:0] subset_size, [38:7] rank
  input  logic [cub_pkg::S_DATA_W-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [MAX_SET_SIZE-1:0] subset_mask
  output logic [((MAX_SET_SIZE+7)/8)*8-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [cub_pkg::STATUS_W-1:0]        m_axis_tuser
);

  localparam int unsigned S      = MAX_SET_SIZE + 1;
  localparam int unsigned DEPTH  = S * S;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned BW     = RANK_BITS + 1;
  localparam int unsigned WW     = 2 * BW;
  localparam int unsigned RW     = (cub_pkg::RANK_W > BW) ? cub_pkg::RANK_W : BW;
  localparam int unsigned NW     = cub_pkg::SIZE_W;
  localparam int unsigned PW     = $clog2(MAX_SET_SIZE);
  localparam int unsigned JW     = $clog2(S);
  localparam int unsigned OUT_W  = ((MAX_SET_SIZE + 7) / 8) * 8;

  localparam logic [BW-1:0] CAP    = {1'b1, {RANK_BITS{1'b0}}};
  localparam logic [RW-1:0] CAP_RW = RW'(CAP);
  localparam logic [NW-1:0] NMAX   = NW'(MAX_SET_SIZE);
  localparam logic [AW-1:0] S_A    = AW'(S);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic [JW-1:0] LAST_J = JW'(MAX_SET_SIZE);

  function automatic logic [AW-1:0] word_addr(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
    word_addr = AW'(row) * S_A + AW'(col);
  endfunction

  cub_pkg::state_e state_q, state_d;

  logic [NW-1:0]  cfg_q;
  logic [AW-1:0]  b_addr_q, b_addr_d;
  logic [JW-1:0]  b_col_q, b_col_d;
  logic           w_v_q;
  logic [AW-1:0]  w_addr_q;
  logic           w_col0_q;
  logic [BW-1:0]  last_hi_q;

  logic [NW-1:0]  n_q, n_d, k_q, k_d, rem_q, rem_d;
  logic [PW-1:0]  p_q, p_d;
  logic [RW-1:0]  rank_q, rank_d;
  logic           pick_lo_q, pick_lo_d;
  logic [MAX_SET_SIZE-1:0] mask_q, mask_d;
  cub_pkg::status_e res_q, res_d;

  logic                    out_v_q, out_v_d;
  logic [MAX_SET_SIZE-1:0] out_mask_q, out_mask_d;
  cub_pkg::status_e        out_status_q, out_status_d;

  logic [AW-1:0]  raddr;
  logic [WW-1:0]  rdata;
  logic [BW-1:0]  rd_hi, rd_lo;
  logic [BW:0]    hi_sum;
  logic [BW-1:0]  new_hi, new_lo;
  logic           b_row0;

  logic [NW-1:0]  n_in, k_in;
  logic [RW-1:0]  rank_in;
  logic           size_err;
  logic [RW-1:0]  cnt;
  logic           chosen;
  logic [NW-1:0]  p_ext;
  logic           walk_done;

  assign rd_hi = rdata[WW-1:BW];
  assign rd_lo = rdata[BW-1:0];

  assign b_row0 = (b_addr_q < S_A);
  assign hi_sum = {1'b0, rd_hi} + {1'b0, rd_lo};
  always_comb begin
    if (w_addr_q < S_A) begin
      new_hi = w_col0_q ? BW'(1) : '0;
    end else if (hi_sum >= {1'b0, CAP}) begin
      new_hi = CAP;
    end else begin
      new_hi = hi_sum[BW-1:0];
    end
    new_lo = w_col0_q ? '0 : last_hi_q;
  end

  assign n_in     = (cfg_q > NMAX) ? NMAX : cfg_q;
  assign k_in     = s_axis_tdata[NW-1:0];
  assign rank_in  = RW'(s_axis_tdata[NW +: cub_pkg::RANK_W]);
  assign size_err = (k_in == '0) || (k_in > n_in);

  assign cnt       = RW'(pick_lo_q ? rd_lo : rd_hi);
  assign chosen    = (rank_q < cnt);
  assign p_ext     = NW'(p_q);
  assign walk_done = ((p_ext + NW'(1)) == n_q) || (chosen && (rem_q == NW'(1)));

  assign s_axis_tready = (state_q == cub_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    b_addr_d     = b_addr_q;
    b_col_d      = b_col_q;
    n_d          = n_q;
    k_d          = k_q;
    rem_d        = rem_q;
    p_d          = p_q;
    rank_d       = rank_q;
    pick_lo_d    = pick_lo_q;
    mask_d       = mask_q;
    res_d        = res_q;
    out_v_d      = out_v_q & ~m_axis_tready;
    out_mask_d   = out_mask_q;
    out_status_d = out_status_q;
    raddr        = '0;

    unique case (state_q)
      cub_pkg::ST_BUILD: begin
        raddr    = b_row0 ? '0 : (b_addr_q - S_A);
        b_addr_d = b_addr_q + AW'(1);
        b_col_d  = (b_col_q == LAST_J) ? '0 : (b_col_q + JW'(1));
        if (b_addr_q == LAST_A) begin
          state_d = cub_pkg::ST_DRAIN;
        end
      end
      cub_pkg::ST_DRAIN: begin
        state_d = cub_pkg::ST_IDLE;
      end
      cub_pkg::ST_IDLE: begin
        raddr = size_err ? '0 : word_addr(n_in, k_in);
        if (s_axis_tvalid) begin
          n_d    = n_in;
          k_d    = k_in;
          rank_d = rank_in;
          mask_d = '0;
          if (size_err) begin
            res_d   = cub_pkg::STATUS_SIZE_ERR;
            state_d = cub_pkg::ST_RESULT;
          end else begin
            state_d = cub_pkg::ST_CHECK;
          end
        end
      end
      cub_pkg::ST_CHECK: begin
        raddr     = word_addr(n_q - NW'(1), k_q);
        p_d       = '0;
        rem_d     = k_q;
        pick_lo_d = 1'b1;
        if ((rank_q >= CAP_RW) || (rank_q >= RW'(rd_hi))) begin
          res_d   = cub_pkg::STATUS_RANK_ERR;
          state_d = cub_pkg::ST_RESULT;
        end else begin
          res_d   = cub_pkg::STATUS_OK;
          state_d = cub_pkg::ST_WALK;
        end
      end
      cub_pkg::ST_WALK: begin
        raddr = walk_done ? '0 : word_addr(n_q - p_ext - NW'(2), rem_q - NW'(1));
        p_d   = p_q + PW'(1);
        if (chosen) begin
          mask_d[p_q] = 1'b1;
          rem_d       = rem_q - NW'(1);
          pick_lo_d   = 1'b1;
        end else begin
          rank_d    = rank_q - cnt;
          pick_lo_d = 1'b0;
        end
        if (walk_done) begin
          state_d = cub_pkg::ST_RESULT;
        end
      end
      cub_pkg::ST_RESULT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d      = 1'b1;
          out_mask_d   = mask_q;
          out_status_d = res_q;
          state_d      = cub_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cub_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cub_pkg::ST_BUILD;
      cfg_q    <= cub_pkg::SET_SIZE_RST;
      b_addr_q <= '0;
      b_col_q  <= '0;
      w_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_wen_i) begin
        cfg_q <= cfg_wdata_i;
      end
      b_addr_q <= b_addr_d;
      b_col_q  <= b_col_d;
      w_v_q    <= (state_q == cub_pkg::ST_BUILD);
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_addr_q     <= b_addr_q;
    w_col0_q     <= (b_col_q == '0);
    if (w_v_q) begin
      last_hi_q <= new_hi;
    end
    n_q          <= n_d;
    k_q          <= k_d;
    rem_q        <= rem_d;
    p_q          <= p_d;
    rank_q       <= rank_d;
    pick_lo_q    <= pick_lo_d;
    mask_q       <= mask_d;
    res_q        <= res_d;
    out_mask_q   <= out_mask_d;
    out_status_q <= out_status_d;
  end

  cub_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_binom_ram (
    .clk_i  (clk_i),
    .we_i   (w_v_q),
    .waddr_i(w_addr_q),
    .wdata_i({new_hi, new_lo}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'(out_mask_q);
  assign m_axis_tuser  = out_status_q;

endmodule
